// ----- hw/rtl/peb_pkg.sv -----
package peb_pkg;

  // Stream payload widths
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 136;
  localparam int NUM_STAGES = 5;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_X    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_Y    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LEFT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_RIGHT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_TOP    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_BOTTOM = 3'd6;

  // Register reset values
  localparam logic signed [31:0] RST_ACCEL_X   = 32'sd0;
  localparam logic signed [31:0] RST_ACCEL_Y   = 32'sd65536000;
  localparam logic [15:0]        RST_TIME_STEP = 16'd1092;
  localparam logic [14:0]        RST_LEFT      = 15'd50;
  localparam logic [14:0]        RST_RIGHT     = 15'd950;
  localparam logic [14:0]        RST_TOP       = 15'd50;
  localparam logic [14:0]        RST_BOTTOM    = 15'd950;

  // Wall hit codes
  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_LEFT   = 2'd1;
  localparam logic [1:0] HIT_RIGHT  = 2'd2;
  localparam logic [1:0] HIT_BOTTOM = 2'd1;
  localparam logic [1:0] HIT_TOP    = 2'd2;

  // Stage 1: inputs plus accel*dt
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [7:0]         radius;
    logic [15:0]        restitution;
    logic signed [31:0] dvx;
    logic signed [31:0] dvy;
  } s1_t;

  // Stage 2: updated velocity
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [7:0]         radius;
    logic [15:0]        restitution;
  } s2_t;

  // Stage 3: position deltas and bounce products
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [7:0]         radius;
    logic signed [31:0] dpx;
    logic signed [31:0] dpy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } s3_t;

  // Stage 4: updated position
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [7:0]         radius;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } s4_t;

  // Stage 5: result
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [1:0]         hit_v;
    logic [1:0]         hit_h;
  } res_t;

  // Q16.16 times unsigned Q0.16, floored to Q16.16
  function automatic logic signed [31:0] mul_floor(input logic signed [31:0] a,
                                                   input logic [15:0] f);
    logic signed [48:0] p;
    p = 49'(a) * 49'($signed({1'b0, f}));
    return p[47:16];
  endfunction

endpackage

// ----- hw/rtl/particle_euler_box_bounce_top.sv -----
// Particle step with box bounce. Each stream transaction carries one particle;
// the block applies one semi-implicit Euler step (velocity gains accel*dt,
// then position gains the new velocity*dt), resolves the bottom/top and
// left/right walls with clamping and a restitution-scaled velocity reversal,
// and returns the new state with the walls hit. Throughput is one particle per
// cycle while out_tready is high. Its five register stages are accel multiply,
// velocity add, dt/restitution multiplies, position add, wall compare and
// clamp. Bubble stages keep accepting while a finished result waits at output.
// The user must write configuration only while idle; nothing enforces it.
module particle_euler_box_bounce_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg port
  input  logic                              cfg_wr_en,
  input  logic [peb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [peb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // in_tdata, low bit up: pos_x[31:0], pos_y[63:32], vel_x[95:64],
  // vel_y[127:96], radius[135:128], restitution[151:136]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [peb_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata, low bit up: new_pos_x[31:0], new_pos_y[63:32],
  // new_vel_x[95:64], new_vel_y[127:96], hit_vertical_wall[129:128],
  // hit_horizontal_wall[131:130], zero pad[135:132]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [peb_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import peb_pkg::*;

  // Configuration registers
  logic signed [31:0] accel_x_r, accel_y_r;
  logic [15:0]        time_step_r;
  logic [14:0]        box_left_r, box_right_r, box_top_r, box_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_x_r    <= RST_ACCEL_X;
      accel_y_r    <= RST_ACCEL_Y;
      time_step_r  <= RST_TIME_STEP;
      box_left_r   <= RST_LEFT;
      box_right_r  <= RST_RIGHT;
      box_top_r    <= RST_TOP;
      box_bottom_r <= RST_BOTTOM;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ACCEL_X:    accel_x_r    <= $signed(cfg_wdata);
        CFG_ACCEL_Y:    accel_y_r    <= $signed(cfg_wdata);
        CFG_TIME_STEP:  time_step_r  <= cfg_wdata[15:0];
        CFG_BOX_LEFT:   box_left_r   <= cfg_wdata[14:0];
        CFG_BOX_RIGHT:  box_right_r  <= cfg_wdata[14:0];
        CFG_BOX_TOP:    box_top_r    <= cfg_wdata[14:0];
        CFG_BOX_BOTTOM: box_bottom_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready = rdy[0];

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  res_t s5_r, s5_nxt;

  // Stage 1: unpack, accel*dt
  always_comb begin
    s1_nxt.pos_x       = $signed(in_tdata[31:0]);
    s1_nxt.pos_y       = $signed(in_tdata[63:32]);
    s1_nxt.vel_x       = $signed(in_tdata[95:64]);
    s1_nxt.vel_y       = $signed(in_tdata[127:96]);
    s1_nxt.radius      = in_tdata[135:128];
    s1_nxt.restitution = in_tdata[151:136];
    s1_nxt.dvx         = mul_floor(accel_x_r, time_step_r);
    s1_nxt.dvy         = mul_floor(accel_y_r, time_step_r);
  end

  // Stage 2: velocity update, wrapping
  always_comb begin
    s2_nxt.pos_x       = s1_r.pos_x;
    s2_nxt.pos_y       = s1_r.pos_y;
    s2_nxt.vel_x       = s1_r.vel_x + s1_r.dvx;
    s2_nxt.vel_y       = s1_r.vel_y + s1_r.dvy;
    s2_nxt.radius      = s1_r.radius;
    s2_nxt.restitution = s1_r.restitution;
  end

  // Stage 3: v*dt for the position, v*e for a possible bounce
  always_comb begin
    s3_nxt.pos_x  = s2_r.pos_x;
    s3_nxt.pos_y  = s2_r.pos_y;
    s3_nxt.vel_x  = s2_r.vel_x;
    s3_nxt.vel_y  = s2_r.vel_y;
    s3_nxt.radius = s2_r.radius;
    s3_nxt.dpx    = mul_floor(s2_r.vel_x, time_step_r);
    s3_nxt.dpy    = mul_floor(s2_r.vel_y, time_step_r);
    s3_nxt.bvx    = mul_floor(s2_r.vel_x, s2_r.restitution);
    s3_nxt.bvy    = mul_floor(s2_r.vel_y, s2_r.restitution);
  end

  // Stage 4: position update, wrapping
  always_comb begin
    s4_nxt.pos_x  = s3_r.pos_x + s3_r.dpx;
    s4_nxt.pos_y  = s3_r.pos_y + s3_r.dpy;
    s4_nxt.vel_x  = s3_r.vel_x;
    s4_nxt.vel_y  = s3_r.vel_y;
    s4_nxt.radius = s3_r.radius;
    s4_nxt.bvx    = s3_r.bvx;
    s4_nxt.bvy    = s3_r.bvy;
  end

  // Stage 5: wall tests (exact, 34 bits) and clamping (wrapping, 32 bits)
  logic signed [33:0] px_w, py_w, rad_w;
  logic signed [33:0] left_w, right_w, top_w, bottom_w;
  logic [31:0]        rad_q;

  always_comb begin
    px_w     = 34'(s4_r.pos_x);
    py_w     = 34'(s4_r.pos_y);
    rad_w    = $signed({10'b0, s4_r.radius, 16'b0});
    rad_q    = {8'b0, s4_r.radius, 16'b0};
    left_w   = $signed({3'b0, box_left_r, 16'b0});
    right_w  = $signed({3'b0, box_right_r, 16'b0});
    top_w    = $signed({3'b0, box_top_r, 16'b0});
    bottom_w = $signed({3'b0, box_bottom_r, 16'b0});

    s5_nxt.pos_x = s4_r.pos_x;
    s5_nxt.pos_y = s4_r.pos_y;
    s5_nxt.vel_x = s4_r.vel_x;
    s5_nxt.vel_y = s4_r.vel_y;
    s5_nxt.hit_v = HIT_NONE;
    s5_nxt.hit_h = HIT_NONE;

    if (py_w + rad_w >= bottom_w) begin
      s5_nxt.pos_y = $signed({1'b0, box_bottom_r, 16'b0} - rad_q);
      s5_nxt.vel_y = -s4_r.bvy;
      s5_nxt.hit_h = HIT_BOTTOM;
    end else if (py_w - rad_w <= top_w) begin
      s5_nxt.pos_y = $signed({1'b0, box_top_r, 16'b0} + rad_q);
      s5_nxt.vel_y = -s4_r.bvy;
      s5_nxt.hit_h = HIT_TOP;
    end

    if (px_w - rad_w <= left_w) begin
      s5_nxt.pos_x = $signed({1'b0, box_left_r, 16'b0} + rad_q);
      s5_nxt.vel_x = -s4_r.bvx;
      s5_nxt.hit_v = HIT_LEFT;
    end else if (px_w + rad_w >= right_w) begin
      s5_nxt.pos_x = $signed({1'b0, box_right_r, 16'b0} - rad_q);
      s5_nxt.vel_x = -s4_r.bvx;
      s5_nxt.hit_v = HIT_RIGHT;
    end
  end

  // Payload registers, loaded when the stage can move
  always_ff @(posedge clk) begin
    if (rdy[0]) s1_r <= s1_nxt;
    if (rdy[1]) s2_r <= s2_nxt;
    if (rdy[2]) s3_r <= s3_nxt;
    if (rdy[3]) s4_r <= s4_nxt;
    if (rdy[4]) s5_r <= s5_nxt;
  end

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = {4'b0, s5_r.hit_h, s5_r.hit_v, s5_r.vel_y, s5_r.vel_x,
                       s5_r.pos_y, s5_r.pos_x};

  // Checks
  a_ready_only_when_empty_or_moving: assert property (@(posedge clk)
    disable iff (!rst_n) !in_tready |-> vld_r[0])
    else $error("input stalled with an empty first stage");

  a_inner_stall_keeps_item: assert property (@(posedge clk)
    disable iff (!rst_n) (vld_r[3] && !rdy[3]) |=> vld_r[3])
    else $error("stalled item dropped from stage 4");

  a_hit_codes: assert property (@(posedge clk)
    disable iff (!rst_n) out_tvalid |-> (s5_r.hit_v != 2'd3 && s5_r.hit_h != 2'd3))
    else $error("illegal wall hit code");

  a_clamp_whole_x: assert property (@(posedge clk)
    disable iff (!rst_n) (out_tvalid && s5_r.hit_v != HIT_NONE) |-> s5_r.pos_x[15:0] == 16'd0)
    else $error("clamped x position has a fraction");

  a_clamp_whole_y: assert property (@(posedge clk)
    disable iff (!rst_n) (out_tvalid && s5_r.hit_h != HIT_NONE) |-> s5_r.pos_y[15:0] == 16'd0)
    else $error("clamped y position has a fraction");

endmodule
